// ===== rtl/core/energy_demand_integrator_macros.svh =====
// Assertion macros shared by the energy and demand integrator RTL.
`ifndef ENERGY_DEMAND_INTEGRATOR_MACROS_SVH
`define ENERGY_DEMAND_INTEGRATOR_MACROS_SVH

// same-cycle implication, checked out of reset
`define EDI_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define EDI_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/edi_pkg.sv =====
// Shared constants, types and tables of the energy and demand integrator.
`timescale 1ns / 1ps
package edi_pkg;

    localparam int RING_SLOTS    = 60;
    localparam int FRACTION_BITS = 16;
    localparam int SLOT_W        = (RING_SLOTS > 1) ? $clog2(RING_SLOTS) : 1;
    localparam int AHEAD_SLOTS   = 15;
    localparam int ENERGY_SCALE  = 120;
    localparam int DEM_SHIFT     = 5;
    localparam int UNIT_SHIFT    = 5;

    localparam int DIV_NUM_W = 36 + FRACTION_BITS;
    localparam int DIV_DEN_W = 24;
    localparam int DIV_CNT_W = $clog2(DIV_NUM_W + 1);
    localparam int ACC_W     = DIV_NUM_W + 2;
    localparam int ESUM_W    = 35;
    localparam int MIN_SUM_W = 7;

    localparam logic signed [ACC_W-1:0] UNIT_ONE =
        ACC_W'(1) << FRACTION_BITS;
    localparam logic signed [ACC_W-1:0] UNIT_BIG =
        ACC_W'(1) << (FRACTION_BITS + UNIT_SHIFT);

    typedef enum logic [1:0] {
        REQ_SAMPLE    = 2'd0,
        REQ_INTEGRATE = 2'd1,
        REQ_DEMAND    = 2'd2,
        REQ_NONE      = 2'd3
    } req_t;

    typedef enum logic [2:0] {
        CFG_RUN        = 3'd0,
        CFG_PT_RATIO   = 3'd1,
        CFG_INTERVAL   = 3'd2,
        CFG_PEAK_START = 3'd3,
        CFG_PEAK_END   = 3'd4,
        CFG_LIMIT      = 3'd5
    } cfg_idx_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

    typedef logic [SLOT_W-1:0] mod_tab_t [2**MIN_SUM_W];

    function automatic mod_tab_t mk_mod_tab();
        mod_tab_t t;
        for (int i = 0; i < 2**MIN_SUM_W; i++) begin
            t[i] = SLOT_W'(i % RING_SLOTS);
        end
        return t;
    endfunction

    localparam mod_tab_t SLOT_MOD = mk_mod_tab();

endpackage

// ===== rtl/core/edi_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module edi_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 60
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/edi_div.sv =====
// Shared restoring divider: signed dividend, unsigned divisor, one bit per cycle.
`timescale 1ns / 1ps
module edi_div (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 start,
    input  logic signed [edi_pkg::DIV_NUM_W-1:0] dividend,
    input  logic [edi_pkg::DIV_DEN_W-1:0]        divisor,
    output edi_pkg::div_stat_t                   stat,
    output logic signed [edi_pkg::DIV_NUM_W-1:0] quotient
);

    logic                            busy_reg, busy_next;
    logic                            done_reg, done_next;
    logic [edi_pkg::DIV_CNT_W-1:0]   cnt_reg, cnt_next;
    logic [edi_pkg::DIV_NUM_W-1:0]   num_reg, num_next;
    logic [edi_pkg::DIV_DEN_W-1:0]   rem_reg, rem_next;
    logic [edi_pkg::DIV_DEN_W-1:0]   den_reg, den_next;
    logic                            neg_reg, neg_next;
    logic [edi_pkg::DIV_DEN_W:0]     trial, diff;
    logic                            ge;

    always_comb begin
        trial     = {rem_reg, num_reg[edi_pkg::DIV_NUM_W-1]};
        diff      = trial - {1'b0, den_reg};
        ge        = (trial >= {1'b0, den_reg});
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        num_next  = num_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        neg_next  = neg_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            den_next  = divisor;
            neg_next  = dividend[edi_pkg::DIV_NUM_W-1];
            num_next  = dividend[edi_pkg::DIV_NUM_W-1] ? 
                        edi_pkg::DIV_NUM_W'(-dividend) : edi_pkg::DIV_NUM_W'(dividend);
        end else if (busy_reg) begin
            rem_next = ge ? diff[edi_pkg::DIV_DEN_W-1:0] : trial[edi_pkg::DIV_DEN_W-1:0];
            num_next = {num_reg[edi_pkg::DIV_NUM_W-2:0], ge};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == edi_pkg::DIV_CNT_W'(edi_pkg::DIV_NUM_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        cnt_reg <= cnt_next;
        num_reg <= num_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
        neg_reg <= neg_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = neg_reg ? -$signed(num_reg) : $signed(num_reg);

endmodule

// ===== rtl/core/energy_demand_integrator.sv =====
// Three-phase energy and demand integrator, top level with sequencer.
//
//  channel   direction  signals
//  s_        in         s_valid/s_ready, request and phase samples
//  m_        out        m_valid/m_ready, energy counters and demands
//  cfg_      in         cfg_wr_en, cfg_index, cfg_wdata
//
// Sample beats accumulate and go straight to ST_DONE; integrate runs 12 divisions on the shared
// divider; demand sums interval_length ring slots (zero counts as one) and divides the sums by it.
// Result is held in an output register; the next beat is taken while it waits,
// and the sequencer stalls at the end only if the previous result is untaken.
// Reset is synchronous; ring slots carry valid bits.
`timescale 1ns / 1ps
`include "energy_demand_integrator_macros.svh"
module energy_demand_integrator (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_req_type,
    input  logic signed [15:0] s_active_r,
    input  logic signed [15:0] s_active_s,
    input  logic signed [15:0] s_active_t,
    input  logic signed [15:0] s_reactive_r,
    input  logic signed [15:0] s_reactive_s,
    input  logic signed [15:0] s_reactive_t,
    input  logic [15:0]        s_apparent_r,
    input  logic [15:0]        s_apparent_s,
    input  logic [15:0]        s_apparent_t,
    input  logic [5:0]         s_minute_now,
    input  logic [4:0]         s_hour_now,
    input  logic               cfg_wr_en,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_wdata,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [31:0]        m_active_energy,
    output logic [31:0]        m_reactive_energy,
    output logic [31:0]        m_apparent_energy_offpeak,
    output logic [31:0]        m_apparent_energy_peak,
    output logic signed [15:0] m_slot_active_demand,
    output logic signed [15:0] m_slot_apparent_demand,
    output logic signed [15:0] m_slot_reactive_demand,
    output logic [15:0]        m_max_active_demand,
    output logic [15:0]        m_max_apparent_demand,
    output logic [15:0]        m_mean_active_demand,
    output logic [15:0]        m_mean_apparent_demand
);

    typedef enum logic [14:0] {
        ST_IDLE  = 15'h0001,
        ST_AVG   = 15'h0002,
        ST_AVGW  = 15'h0004,
        ST_MUL   = 15'h0008,
        ST_DEM   = 15'h0010,
        ST_EDIV  = 15'h0020,
        ST_EDIVW = 15'h0040,
        ST_CARRY = 15'h0080,
        ST_REM   = 15'h0100,
        ST_RING  = 15'h0200,
        ST_DRD   = 15'h0400,
        ST_DACC  = 15'h0800,
        ST_DDIV  = 15'h1000,
        ST_DDIVW = 15'h2000,
        ST_DONE  = 15'h4000
    } state_t;

    localparam int NUM_W = edi_pkg::DIV_NUM_W;
    localparam int ACC_W = edi_pkg::ACC_W;
    localparam int SW    = edi_pkg::SLOT_W;
    localparam int RING_V = edi_pkg::RING_SLOTS;

    state_t state_reg, state_next;

    // configuration
    logic        run_reg, run_next;
    logic [9:0]  pt_reg, pt_next;
    logic [5:0]  ilen_reg, ilen_next;
    logic [4:0]  pstart_reg, pstart_next;
    logic [4:0]  pend_reg, pend_next;
    logic [31:0] limit_reg, limit_next;

    // architectural state
    logic [31:0]        sum_reg [9];
    logic [31:0]        sum_next [9];
    logic [15:0]        count_reg, count_next;
    logic [31:0]        res_reg [3];
    logic [31:0]        res_next [3];
    logic [31:0]        ecnt_reg [4];
    logic [31:0]        ecnt_next [4];
    logic [15:0]        peak_act_reg, peak_act_next;
    logic [15:0]        peak_app_reg, peak_app_next;
    logic [15:0]        slot_act_reg, slot_act_next;
    logic [15:0]        slot_app_reg, slot_app_next;
    logic [15:0]        slot_rea_reg, slot_rea_next;
    logic [15:0]        mean_act_reg, mean_act_next;
    logic [15:0]        mean_app_reg, mean_app_next;
    logic [RING_V-1:0]  vld_reg, vld_next;
    logic               m_valid_reg, m_valid_next;

    // working registers
    logic [5:0]                minute_reg, minute_next;
    logic [4:0]                hour_reg, hour_next;
    logic [1:0]                g_reg, g_next;
    logic [1:0]                k_reg, k_next;
    logic signed [17:0]        tot_reg, tot_next;
    logic signed [edi_pkg::ESUM_W-1:0] esum_reg, esum_next;
    logic signed [28:0]        prod_reg, prod_next;
    logic signed [ACC_W-1:0]   acc_reg, acc_next;
    logic signed [ACC_W-1:0]   whole_reg, whole_next;
    logic                      over_reg, over_next;
    logic [SW-1:0]             slot_reg, slot_next;
    logic [5:0]                n_reg, n_next;
    logic                      first_reg, first_next;
    logic [21:0]               sa_reg, sa_next;
    logic [21:0]               sp_reg, sp_next;
    logic                      dsel_reg, dsel_next;
    logic                      rvld_reg;

    // output register
    logic [31:0] o_ae_reg, o_re_reg, o_off_reg, o_pk_reg;
    logic [15:0] o_sa_reg, o_sp_reg, o_sr_reg, o_ma_reg, o_mp_reg, o_na_reg, o_np_reg;
    logic        out_load;

    // datapath wires
    logic                      div_start;
    logic signed [NUM_W-1:0]   div_num;
    logic [edi_pkg::DIV_DEN_W-1:0] div_den;
    edi_pkg::div_stat_t        div_stat;
    logic signed [NUM_W-1:0]   div_q;
    logic [3:0]                idx;
    logic [31:0]               ph_raw;
    logic signed [NUM_W-1:0]   ph_val;
    logic [22:0]               count_x;
    logic signed [28:0]        dem_bias, dem_full;
    logic signed [ACC_W-1:0]   unit_cur, whole_pre, rem_full, wfin;
    logic                      g_unit_small;
    logic [SW-1:0]             prev_slot, ahead_slot, slot_dec, raddr;
    logic                      ram_we;
    logic [31:0]               ram_wdata, ram_rdata;
    logic [15:0]               rd_act, rd_app, pk_a, pk_p;
    logic [5:0]                len;
    logic                      in_peak;
    logic                      acc_fire;

    assign acc_fire   = s_valid && s_ready;
    assign s_ready    = (state_reg == ST_IDLE);
    assign idx        = 4'({g_reg, 1'b0}) + 4'(g_reg) + 4'(k_reg);
    assign ph_raw     = sum_reg[idx];
    assign ph_val     = (idx < 4'd6) ? NUM_W'($signed(ph_raw)) : NUM_W'({1'b0, ph_raw});
    assign count_x    = 23'(count_reg) * 23'(edi_pkg::ENERGY_SCALE);
    assign prev_slot  = edi_pkg::SLOT_MOD[7'(minute_reg) + 7'(edi_pkg::RING_SLOTS - 1)];
    assign ahead_slot = edi_pkg::SLOT_MOD[7'(minute_reg) + 7'(edi_pkg::AHEAD_SLOTS)];
    assign slot_dec   = (slot_reg == '0) ? SW'(edi_pkg::RING_SLOTS - 1) : slot_reg - 1'b1;
    assign len        = (ilen_reg == '0) ? 6'd1 : ilen_reg;
    assign in_peak    = (hour_reg >= pstart_reg) && (hour_reg < pend_reg);
    assign g_unit_small = (g_reg == 2'd1);
    assign unit_cur   = g_unit_small ? edi_pkg::UNIT_ONE : edi_pkg::UNIT_BIG;
    assign rd_act     = rvld_reg ? ram_rdata[15:0] : 16'd0;
    assign rd_app     = rvld_reg ? ram_rdata[31:16] : 16'd0;
    assign dem_bias   = prod_reg + (prod_reg[28] ? 29'((1 << edi_pkg::DEM_SHIFT) - 1) : 29'd0);
    assign dem_full   = dem_bias >>> edi_pkg::DEM_SHIFT;
    assign whole_pre  = acc_reg + (acc_reg[ACC_W-1] ? (unit_cur - 1'b1) : '0);
    assign wfin       = (g_reg == 2'd2 && !over_reg) ? '0 : whole_reg;
    assign rem_full   = acc_reg - (g_unit_small ? (wfin <<< edi_pkg::FRACTION_BITS)
                        : (wfin <<< (edi_pkg::FRACTION_BITS + edi_pkg::UNIT_SHIFT)));
    assign out_load   = (state_reg == ST_DONE) && (!m_valid_reg || m_ready);

    edi_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_num),
        .divisor  (div_den),
        .stat     (div_stat),
        .quotient (div_q)
    );

    edi_ram #(
        .WIDTH (32),
        .DEPTH (edi_pkg::RING_SLOTS)
    ) u_ring (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (prev_slot),
        .wdata (ram_wdata),
        .raddr (raddr),
        .rdata (ram_rdata)
    );

    always_comb begin
        state_next    = state_reg;
        run_next      = run_reg;
        pt_next       = pt_reg;
        ilen_next     = ilen_reg;
        pstart_next   = pstart_reg;
        pend_next     = pend_reg;
        limit_next    = limit_reg;
        sum_next      = sum_reg;
        count_next    = count_reg;
        res_next      = res_reg;
        ecnt_next     = ecnt_reg;
        peak_act_next = peak_act_reg;
        peak_app_next = peak_app_reg;
        slot_act_next = slot_act_reg;
        slot_app_next = slot_app_reg;
        slot_rea_next = slot_rea_reg;
        mean_act_next = mean_act_reg;
        mean_app_next = mean_app_reg;
        vld_next      = vld_reg;
        m_valid_next  = m_valid_reg;
        minute_next   = minute_reg;
        hour_next     = hour_reg;
        g_next        = g_reg;
        k_next        = k_reg;
        tot_next      = tot_reg;
        esum_next     = esum_reg;
        prod_next     = prod_reg;
        acc_next      = acc_reg;
        whole_next    = whole_reg;
        over_next     = over_reg;
        slot_next     = slot_reg;
        n_next        = n_reg;
        first_next    = first_reg;
        sa_next       = sa_reg;
        sp_next       = sp_reg;
        dsel_next     = dsel_reg;
        div_start     = 1'b0;
        div_num       = ph_val;
        div_den       = edi_pkg::DIV_DEN_W'(count_reg);
        ram_we        = 1'b0;
        ram_wdata     = {slot_app_reg, slot_act_reg};
        raddr         = slot_reg;
        pk_a          = peak_act_reg;
        pk_p          = peak_app_reg;

        if (cfg_wr_en) begin
            case (cfg_index)
                edi_pkg::CFG_RUN:        run_next    = cfg_wdata[0];
                edi_pkg::CFG_PT_RATIO:   pt_next     = cfg_wdata[9:0];
                edi_pkg::CFG_INTERVAL:   ilen_next   = cfg_wdata[5:0];
                edi_pkg::CFG_PEAK_START: pstart_next = cfg_wdata[4:0];
                edi_pkg::CFG_PEAK_END:   pend_next   = cfg_wdata[4:0];
                edi_pkg::CFG_LIMIT:      limit_next  = cfg_wdata;
                default: ;
            endcase
        end

        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (acc_fire) begin
                    minute_next = s_minute_now;
                    hour_next   = s_hour_now;
                    state_next  = ST_DONE;
                    if (run_reg) begin
                        case (s_req_type)
                            edi_pkg::REQ_SAMPLE: begin
                                sum_next[0] = sum_reg[0] + 32'(s_active_r);
                                sum_next[1] = sum_reg[1] + 32'(s_active_s);
                                sum_next[2] = sum_reg[2] + 32'(s_active_t);
                                sum_next[3] = sum_reg[3] + 32'(s_reactive_r);
                                sum_next[4] = sum_reg[4] + 32'(s_reactive_s);
                                sum_next[5] = sum_reg[5] + 32'(s_reactive_t);
                                sum_next[6] = sum_reg[6] + 32'(s_apparent_r);
                                sum_next[7] = sum_reg[7] + 32'(s_apparent_s);
                                sum_next[8] = sum_reg[8] + 32'(s_apparent_t);
                                count_next  = count_reg + 1'b1;
                            end
                            edi_pkg::REQ_INTEGRATE: begin
                                g_next     = '0;
                                k_next     = '0;
                                tot_next   = '0;
                                esum_next  = '0;
                                state_next = ST_AVG;
                            end
                            edi_pkg::REQ_DEMAND: begin
                                slot_next  = edi_pkg::SLOT_MOD[7'(s_minute_now)
                                             + 7'(edi_pkg::RING_SLOTS - 1)];
                                state_next = ST_DRD;
                            end
                            default: ;
                        endcase
                    end
                end
            end
            ST_AVG: begin
                div_start  = 1'b1;
                state_next = ST_AVGW;
            end
            ST_AVGW: begin
                if (div_stat.done) begin
                    if (count_reg != '0) begin
                        tot_next = tot_reg + 18'($signed(div_q[15:0]));
                    end
                    esum_next = esum_reg + edi_pkg::ESUM_W'(ph_val);
                    if (k_reg == 2'd2) begin
                        state_next = ST_MUL;
                    end else begin
                        k_next     = k_reg + 1'b1;
                        state_next = ST_AVG;
                    end
                end
            end
            ST_MUL: begin
                prod_next  = 29'(tot_reg * $signed({1'b0, pt_reg}));
                state_next = ST_DEM;
            end
            ST_DEM: begin
                case (g_reg)
                    2'd0:    slot_act_next = dem_full[15:0];
                    2'd1:    slot_rea_next = dem_full[15:0];
                    default: slot_app_next = dem_full[15:0];
                endcase
                state_next = ST_EDIV;
            end
            ST_EDIV: begin
                div_num    = NUM_W'(esum_reg) <<< edi_pkg::FRACTION_BITS;
                div_den    = edi_pkg::DIV_DEN_W'(count_x);
                div_start  = 1'b1;
                state_next = ST_EDIVW;
            end
            ST_EDIVW: begin
                if (div_stat.done) begin
                    acc_next = ACC_W'($signed(res_reg[g_reg]))
                             + ((count_reg != '0) ? ACC_W'(div_q) : '0);
                    state_next = ST_CARRY;
                end
            end
            ST_CARRY: begin
                whole_next = g_unit_small ? (whole_pre >>> edi_pkg::FRACTION_BITS)
                           : (whole_pre >>> (edi_pkg::FRACTION_BITS + edi_pkg::UNIT_SHIFT));
                over_next  = (acc_reg > unit_cur);
                state_next = ST_REM;
            end
            ST_REM: begin
                res_next[g_reg] = rem_full[31:0];
                case (g_reg)
                    2'd0: ecnt_next[0] = ecnt_reg[0] + wfin[31:0];
                    2'd1: ecnt_next[1] = ecnt_reg[1] + wfin[31:0];
                    default: begin
                        if (in_peak) begin
                            ecnt_next[3] = ecnt_reg[3] + wfin[31:0];
                        end else begin
                            ecnt_next[2] = ecnt_reg[2] + wfin[31:0];
                        end
                    end
                endcase
                if (g_reg == 2'd2) begin
                    state_next = ST_RING;
                end else begin
                    g_next     = g_reg + 1'b1;
                    k_next     = '0;
                    tot_next   = '0;
                    esum_next  = '0;
                    state_next = ST_AVG;
                end
            end
            ST_RING: begin
                ram_we               = 1'b1;
                vld_next[prev_slot]  = 1'b1;
                vld_next[ahead_slot] = 1'b0;
                for (int i = 0; i < 9; i++) begin
                    sum_next[i] = '0;
                end
                count_next = '0;
                state_next = ST_DONE;
            end
            ST_DRD: begin
                n_next     = '0;
                first_next = 1'b1;
                sa_next    = '0;
                sp_next    = '0;
                state_next = ST_DACC;
            end
            ST_DACC: begin
                raddr = slot_dec;
                if (first_reg) begin
                    pk_a = (peak_act_reg < rd_act) ? rd_act : peak_act_reg;
                    pk_p = (peak_app_reg < rd_app) ? rd_app : peak_app_reg;
                    peak_act_next = ({16'd0, pk_a} > limit_reg) ? 16'd0 : pk_a;
                    peak_app_next = ({16'd0, pk_p} > limit_reg) ? 16'd0 : pk_p;
                end
                first_next = 1'b0;
                sa_next    = sa_reg + 22'(rd_act);
                sp_next    = sp_reg + 22'(rd_app);
                n_next     = n_reg + 1'b1;
                if (6'(n_reg + 1'b1) == len) begin
                    dsel_next  = 1'b0;
                    state_next = ST_DDIV;
                end else begin
                    slot_next = slot_dec;
                end
            end
            ST_DDIV: begin
                div_num    = NUM_W'(dsel_reg ? sp_reg : sa_reg);
                div_den    = edi_pkg::DIV_DEN_W'(len);
                div_start  = 1'b1;
                state_next = ST_DDIVW;
            end
            ST_DDIVW: begin
                if (div_stat.done) begin
                    if (dsel_reg) begin
                        mean_app_next = div_q[15:0];
                        state_next    = ST_DONE;
                    end else begin
                        mean_act_next = div_q[15:0];
                        dsel_next     = 1'b1;
                        state_next    = ST_DDIV;
                    end
                end
            end
            ST_DONE: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            run_reg      <= 1'b0;
            pt_reg       <= 10'd1;
            ilen_reg     <= 6'd15;
            pstart_reg   <= 5'd18;
            pend_reg     <= 5'd21;
            limit_reg    <= 32'hFFFF_FFFF;
            for (int i = 0; i < 9; i++) begin
                sum_reg[i] <= '0;
            end
            for (int i = 0; i < 3; i++) begin
                res_reg[i] <= '0;
            end
            for (int i = 0; i < 4; i++) begin
                ecnt_reg[i] <= '0;
            end
            count_reg    <= '0;
            peak_act_reg <= '0;
            peak_app_reg <= '0;
            slot_act_reg <= '0;
            slot_app_reg <= '0;
            slot_rea_reg <= '0;
            mean_act_reg <= '0;
            mean_app_reg <= '0;
            vld_reg      <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            run_reg      <= run_next;
            pt_reg       <= pt_next;
            ilen_reg     <= ilen_next;
            pstart_reg   <= pstart_next;
            pend_reg     <= pend_next;
            limit_reg    <= limit_next;
            sum_reg      <= sum_next;
            res_reg      <= res_next;
            ecnt_reg     <= ecnt_next;
            count_reg    <= count_next;
            peak_act_reg <= peak_act_next;
            peak_app_reg <= peak_app_next;
            slot_act_reg <= slot_act_next;
            slot_app_reg <= slot_app_next;
            slot_rea_reg <= slot_rea_next;
            mean_act_reg <= mean_act_next;
            mean_app_reg <= mean_app_next;
            vld_reg      <= vld_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        minute_reg <= minute_next;
        hour_reg   <= hour_next;
        g_reg      <= g_next;
        k_reg      <= k_next;
        tot_reg    <= tot_next;
        esum_reg   <= esum_next;
        prod_reg   <= prod_next;
        acc_reg    <= acc_next;
        whole_reg  <= whole_next;
        over_reg   <= over_next;
        slot_reg   <= slot_next;
        n_reg      <= n_next;
        first_reg  <= first_next;
        sa_reg     <= sa_next;
        sp_reg     <= sp_next;
        dsel_reg   <= dsel_next;
        rvld_reg   <= vld_reg[raddr];
        if (out_load) begin
            o_ae_reg  <= ecnt_reg[0];
            o_re_reg  <= ecnt_reg[1];
            o_off_reg <= ecnt_reg[2];
            o_pk_reg  <= ecnt_reg[3];
            o_sa_reg  <= slot_act_reg;
            o_sp_reg  <= slot_app_reg;
            o_sr_reg  <= slot_rea_reg;
            o_ma_reg  <= peak_act_reg;
            o_mp_reg  <= peak_app_reg;
            o_na_reg  <= mean_act_reg;
            o_np_reg  <= mean_app_reg;
        end
    end

    assign m_valid                   = m_valid_reg;
    assign m_active_energy           = o_ae_reg;
    assign m_reactive_energy         = o_re_reg;
    assign m_apparent_energy_offpeak = o_off_reg;
    assign m_apparent_energy_peak    = o_pk_reg;
    assign m_slot_active_demand      = $signed(o_sa_reg);
    assign m_slot_apparent_demand    = $signed(o_sp_reg);
    assign m_slot_reactive_demand    = $signed(o_sr_reg);
    assign m_max_active_demand       = o_ma_reg;
    assign m_max_apparent_demand     = o_mp_reg;
    assign m_mean_active_demand      = o_na_reg;
    assign m_mean_apparent_demand    = o_np_reg;

    `EDI_ASSERT_NXT(a_load_sets_valid, out_load, m_valid, "result load did not raise m_valid")
    `EDI_ASSERT_IMP(a_div_idle_start, div_start, !div_stat.busy, "divider restarted while busy")
    `EDI_ASSERT_IMP(a_div_done_wait, div_stat.done, (state_reg == ST_AVGW || state_reg == ST_EDIVW || state_reg == ST_DDIVW), "divider finished outside a wait state")
    `EDI_ASSERT_IMP(a_slot_range, state_reg == ST_DACC, slot_reg < SW'(edi_pkg::RING_SLOTS), "ring walk slot out of range")

endmodule

// ===== tb/edi_checker.sv =====
// Checker for the energy and demand integrator: predicts each result and compares it.
`timescale 1ns / 1ps
module edi_checker
    import edi_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    input  logic               s_ready,
    input  logic [1:0]         s_req_type,
    input  logic signed [15:0] s_active_r,
    input  logic signed [15:0] s_active_s,
    input  logic signed [15:0] s_active_t,
    input  logic signed [15:0] s_reactive_r,
    input  logic signed [15:0] s_reactive_s,
    input  logic signed [15:0] s_reactive_t,
    input  logic [15:0]        s_apparent_r,
    input  logic [15:0]        s_apparent_s,
    input  logic [15:0]        s_apparent_t,
    input  logic [5:0]         s_minute_now,
    input  logic [4:0]         s_hour_now,
    input  logic               cfg_wr_en,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_wdata,
    input  logic               m_valid,
    input  logic               m_ready,
    input  logic [31:0]        m_active_energy,
    input  logic [31:0]        m_reactive_energy,
    input  logic [31:0]        m_apparent_energy_offpeak,
    input  logic [31:0]        m_apparent_energy_peak,
    input  logic signed [15:0] m_slot_active_demand,
    input  logic signed [15:0] m_slot_apparent_demand,
    input  logic signed [15:0] m_slot_reactive_demand,
    input  logic [15:0]        m_max_active_demand,
    input  logic [15:0]        m_max_apparent_demand,
    input  logic [15:0]        m_mean_active_demand,
    input  logic [15:0]        m_mean_apparent_demand,
    output int                 errors,
    output int                 pending
);

    typedef struct {
        logic [31:0] act_e, rea_e, app_off, app_pk;
        logic [15:0] slot_a, slot_p, slot_r, max_a, max_p, mean_a, mean_p;
    } meter_out_t;

    meter_out_t meter_q[$];

    logic        run_en;
    logic [9:0]  pt;
    logic [5:0]  ivl;
    logic [4:0]  pk_start, pk_end;
    logic [31:0] ovr_limit;

    logic [31:0] psum[9];
    logic [15:0] n_samples;
    int          resid[3];
    logic [31:0] ectr[4];
    logic [15:0] act_ring[RING_SLOTS];
    logic [15:0] app_ring[RING_SLOTS];
    logic [15:0] peak_dem[2];
    logic [15:0] held[5];

    function automatic longint psum_val(int i);
        return (i < 6) ? longint'($signed(psum[i])) : longint'(psum[i]);
    endfunction

    function automatic logic [15:0] slot_demand(int g);
        longint tot, avg;
        tot = 0;
        for (int k = 0; k < 3; k++) begin
            avg = (n_samples != 0) ? psum_val(g * 3 + k) / longint'(n_samples) : 0;
            tot += longint'($signed(avg[15:0]));
        end
        tot = tot * longint'(pt) / 32;
        return tot[15:0];
    endfunction

    function automatic logic [31:0] carry_units(int g, longint unit, bit need_over);
        longint tot, inc, acc, whole;
        tot = psum_val(g * 3) + psum_val(g * 3 + 1) + psum_val(g * 3 + 2);
        inc = (n_samples != 0) ?
            tot * (longint'(1) << FRACTION_BITS) / (longint'(n_samples) * 120) : 0;
        acc = longint'(resid[g]) + inc;
        whole = acc / unit;
        if (need_over && !(acc > unit))
            whole = 0;
        resid[g] = int'(acc - whole * unit);
        return whole[31:0];
    endfunction

    task automatic report_mismatch(string fld, longint got, longint want);
        $display("%0t mismatch %s: got %0h want %0h", $time, fld, got, want);
        errors++;
    endtask

    task automatic integrate_interval(int minute, int hour);
        int prev, ahead;
        logic [31:0] w;
        prev = (minute + RING_SLOTS - 1) % RING_SLOTS;
        ahead = (minute + 15) % RING_SLOTS;
        held[0] = slot_demand(0);
        held[2] = slot_demand(1);
        held[1] = slot_demand(2);
        act_ring[prev] = held[0];
        app_ring[prev] = held[1];
        act_ring[ahead] = 0;
        app_ring[ahead] = 0;
        ectr[0] += carry_units(0, longint'(32) << FRACTION_BITS, 1'b0);
        ectr[1] += carry_units(1, longint'(1) << FRACTION_BITS, 1'b0);
        w = carry_units(2, longint'(32) << FRACTION_BITS, 1'b1);
        if (hour >= pk_start && hour < pk_end)
            ectr[3] += w;
        else
            ectr[2] += w;
        for (int k = 0; k < 9; k++)
            psum[k] = 0;
        n_samples = 0;
    endtask

    task automatic update_demand(int minute);
        int slot, len;
        logic [31:0] sa, sp;
        slot = (minute + RING_SLOTS - 1) % RING_SLOTS;
        len = (ivl != 0) ? ivl : 1;
        sa = 0;
        sp = 0;
        if (peak_dem[0] < act_ring[slot]) peak_dem[0] = act_ring[slot];
        if (peak_dem[1] < app_ring[slot]) peak_dem[1] = app_ring[slot];
        if (32'(peak_dem[0]) > ovr_limit) peak_dem[0] = 0;
        if (32'(peak_dem[1]) > ovr_limit) peak_dem[1] = 0;
        for (int i = 0; i < len; i++) begin
            sa += act_ring[slot];
            sp += app_ring[slot];
            slot = (slot + RING_SLOTS - 1) % RING_SLOTS;
        end
        held[3] = 16'(sa / len);
        held[4] = 16'(sp / len);
    endtask

    always @(posedge aclk) begin
        meter_out_t e;
        if (!aresetn) begin
            meter_q.delete();
            errors = 0;
            run_en = 0; pt = 1; ivl = 15; pk_start = 18; pk_end = 21;
            ovr_limit = '1;
            for (int k = 0; k < 9; k++) psum[k] = 0;
            n_samples = 0;
            for (int k = 0; k < 3; k++) resid[k] = 0;
            for (int k = 0; k < 4; k++) ectr[k] = 0;
            for (int k = 0; k < RING_SLOTS; k++) begin
                act_ring[k] = 0;
                app_ring[k] = 0;
            end
            peak_dem[0] = 0; peak_dem[1] = 0;
            for (int k = 0; k < 5; k++) held[k] = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (meter_q.size() == 0) begin
                    report_mismatch("unexpected beat", 0, 0);
                end else begin
                    e = meter_q.pop_front();
                    if (m_active_energy !== e.act_e)
                        report_mismatch("active_energy", m_active_energy, e.act_e);
                    if (m_reactive_energy !== e.rea_e)
                        report_mismatch("reactive_energy", m_reactive_energy, e.rea_e);
                    if (m_apparent_energy_offpeak !== e.app_off)
                        report_mismatch("apparent_offpeak", m_apparent_energy_offpeak,
                                        e.app_off);
                    if (m_apparent_energy_peak !== e.app_pk)
                        report_mismatch("apparent_peak", m_apparent_energy_peak, e.app_pk);
                    if (m_slot_active_demand !== e.slot_a)
                        report_mismatch("slot_active", m_slot_active_demand, e.slot_a);
                    if (m_slot_apparent_demand !== e.slot_p)
                        report_mismatch("slot_apparent", m_slot_apparent_demand, e.slot_p);
                    if (m_slot_reactive_demand !== e.slot_r)
                        report_mismatch("slot_reactive", m_slot_reactive_demand, e.slot_r);
                    if (m_max_active_demand !== e.max_a)
                        report_mismatch("max_active", m_max_active_demand, e.max_a);
                    if (m_max_apparent_demand !== e.max_p)
                        report_mismatch("max_apparent", m_max_apparent_demand, e.max_p);
                    if (m_mean_active_demand !== e.mean_a)
                        report_mismatch("mean_active", m_mean_active_demand, e.mean_a);
                    if (m_mean_apparent_demand !== e.mean_p)
                        report_mismatch("mean_apparent", m_mean_apparent_demand, e.mean_p);
                end
            end
            if (cfg_wr_en) begin
                case (cfg_idx_t'(cfg_index))
                    CFG_RUN:        run_en = cfg_wdata[0];
                    CFG_PT_RATIO:   pt = cfg_wdata[9:0];
                    CFG_INTERVAL:   ivl = cfg_wdata[5:0];
                    CFG_PEAK_START: pk_start = cfg_wdata[4:0];
                    CFG_PEAK_END:   pk_end = cfg_wdata[4:0];
                    CFG_LIMIT:      ovr_limit = cfg_wdata;
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                if (run_en) begin
                    case (req_t'(s_req_type))
                        REQ_SAMPLE: begin
                            psum[0] += 32'(s_active_r);
                            psum[1] += 32'(s_active_s);
                            psum[2] += 32'(s_active_t);
                            psum[3] += 32'(s_reactive_r);
                            psum[4] += 32'(s_reactive_s);
                            psum[5] += 32'(s_reactive_t);
                            psum[6] += 32'(s_apparent_r);
                            psum[7] += 32'(s_apparent_s);
                            psum[8] += 32'(s_apparent_t);
                            n_samples += 1;
                        end
                        REQ_INTEGRATE: integrate_interval(s_minute_now, s_hour_now);
                        REQ_DEMAND:    update_demand(s_minute_now);
                        default: ;
                    endcase
                end
                e.act_e = ectr[0]; e.rea_e = ectr[1];
                e.app_off = ectr[2]; e.app_pk = ectr[3];
                e.slot_a = held[0]; e.slot_p = held[1]; e.slot_r = held[2];
                e.max_a = peak_dem[0]; e.max_p = peak_dem[1];
                e.mean_a = held[3]; e.mean_p = held[4];
                meter_q.push_back(e);
            end
        end
        pending = meter_q.size();
    end

endmodule

// ===== tb/tb_top.sv =====
// Testbench top for the energy and demand integrator: stimulus, watchdog and verdict.
`timescale 1ns / 1ps
module tb_top;
    import edi_pkg::*;

    localparam int STALL_LIMIT = 5000;

    typedef struct {
        req_t        req;
        logic [15:0] act[3], rea[3], app[3];
        logic [5:0]  minute;
        logic [4:0]  hour;
    } meter_item_t;

    logic               aclk, aresetn;
    logic               s_valid, s_ready;
    logic [1:0]         s_req_type;
    logic signed [15:0] s_active_r, s_active_s, s_active_t;
    logic signed [15:0] s_reactive_r, s_reactive_s, s_reactive_t;
    logic [15:0]        s_apparent_r, s_apparent_s, s_apparent_t;
    logic [5:0]         s_minute_now;
    logic [4:0]         s_hour_now;
    logic               cfg_wr_en;
    logic [2:0]         cfg_index;
    logic [31:0]        cfg_wdata;
    logic               m_valid, m_ready;
    logic [31:0]        m_active_energy, m_reactive_energy;
    logic [31:0]        m_apparent_energy_offpeak, m_apparent_energy_peak;
    logic signed [15:0] m_slot_active_demand, m_slot_apparent_demand;
    logic signed [15:0] m_slot_reactive_demand;
    logic [15:0]        m_max_active_demand, m_max_apparent_demand;
    logic [15:0]        m_mean_active_demand, m_mean_apparent_demand;
    int                 errors, pending;
    bit                 calm;
    int                 m_stall, idle_cycles;
    int                 minute_seq;

    energy_demand_integrator dut (.*);
    edi_checker checker_i (.*);

    initial begin
        aclk = 0;
        forever #6 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 0;
            m_stall <= 0;
        end else if (m_ready) begin
            if (m_valid) begin
                m_stall <= calm ? 0 : $urandom_range(0, 3);
                m_ready <= calm || ($urandom_range(0, 3) == 0);
            end
        end else begin
            if (m_stall <= 1) m_ready <= 1;
            m_stall <= m_stall - 1;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("status: fail");
                $finish;
            end
        end
    end

    task automatic send_beat(meter_item_t it);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            s_valid <= 0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1;
        s_req_type <= it.req;
        s_active_r <= it.act[0]; s_active_s <= it.act[1]; s_active_t <= it.act[2];
        s_reactive_r <= it.rea[0]; s_reactive_s <= it.rea[1]; s_reactive_t <= it.rea[2];
        s_apparent_r <= it.app[0]; s_apparent_s <= it.app[1]; s_apparent_t <= it.app[2];
        s_minute_now <= it.minute;
        s_hour_now <= it.hour;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic drain();
        s_valid <= 0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (800) @(posedge aclk);
    endtask

    task automatic write_reg(cfg_idx_t idx, logic [31:0] val);
        cfg_wr_en <= 1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 0;
        @(posedge aclk);
    endtask

    function automatic logic [15:0] rand_power();
        case ($urandom_range(0, 9))
            0: return 16'h7fff;
            1: return 16'h8000;
            2: return 16'hffff;
            3: return 16'h0000;
            4, 5: return 16'($urandom_range(0, 3000));
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic meter_item_t make_item(req_t req, logic [15:0] v, int minute, int hour);
        meter_item_t it;
        it.req = req;
        for (int k = 0; k < 3; k++) begin
            it.act[k] = v;
            it.rea[k] = v;
            it.app[k] = v;
        end
        it.minute = 6'(minute);
        it.hour = 5'(hour);
        return it;
    endfunction

    function automatic meter_item_t rand_item();
        meter_item_t it;
        int r;
        r = $urandom_range(0, 99);
        it.req = (r < 62) ? REQ_SAMPLE : (r < 80) ? REQ_INTEGRATE :
                 (r < 96) ? REQ_DEMAND : REQ_NONE;
        for (int k = 0; k < 3; k++) begin
            it.act[k] = rand_power();
            it.rea[k] = rand_power();
            it.app[k] = rand_power();
        end
        if ($urandom_range(0, 4) == 0) begin
            it.minute = 6'($urandom_range(0, 63));
        end else begin
            it.minute = 6'(minute_seq);
            if (it.req == REQ_INTEGRATE) minute_seq = (minute_seq + 1) % RING_SLOTS;
        end
        it.hour = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(24, 31))
                                               : 5'($urandom_range(0, 23));
        return it;
    endfunction

    initial begin
        logic [31:0] lim;
        aresetn = 0;
        s_valid = 0;
        s_req_type = 0;
        {s_active_r, s_active_s, s_active_t} = '0;
        {s_reactive_r, s_reactive_s, s_reactive_t} = '0;
        {s_apparent_r, s_apparent_s, s_apparent_t} = '0;
        s_minute_now = 0;
        s_hour_now = 0;
        cfg_wr_en = 0;
        cfg_index = 0;
        cfg_wdata = 0;
        calm = 0;
        minute_seq = 0;
        repeat (10) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // not running: nothing changes
        send_beat(make_item(REQ_SAMPLE, 16'h7fff, 0, 0));
        send_beat(make_item(REQ_INTEGRATE, 16'h0, 1, 19));
        drain();

        write_reg(CFG_RUN, 1);
        write_reg(CFG_PT_RATIO, 1000);
        write_reg(CFG_INTERVAL, 0);
        write_reg(CFG_PEAK_START, 0);
        write_reg(CFG_PEAK_END, 24);
        write_reg(CFG_LIMIT, 32'hffff_ffff);
        send_beat(make_item(REQ_INTEGRATE, 16'h0, 0, 5));
        send_beat(make_item(REQ_SAMPLE, 16'h7fff, 0, 0));
        send_beat(make_item(REQ_SAMPLE, 16'h7fff, 0, 0));
        send_beat(make_item(REQ_INTEGRATE, 16'h0, 1, 23));
        send_beat(make_item(REQ_DEMAND, 16'h0, 1, 0));
        send_beat(make_item(REQ_SAMPLE, 16'h8000, 0, 0));
        send_beat(make_item(REQ_SAMPLE, 16'hffff, 0, 0));
        send_beat(make_item(REQ_INTEGRATE, 16'h0, 2, 24));
        send_beat(make_item(REQ_DEMAND, 16'h0, 2, 0));
        send_beat(make_item(REQ_NONE, 16'h5555, 3, 0));
        send_beat(make_item(REQ_SAMPLE, 16'h1234, 0, 0));
        send_beat(make_item(REQ_INTEGRATE, 16'h0, 63, 31));
        send_beat(make_item(REQ_DEMAND, 16'h0, 63, 0));
        send_beat(make_item(REQ_DEMAND, 16'h0, 0, 0));
        drain();
        write_reg(CFG_INTERVAL, 63);
        write_reg(CFG_LIMIT, 0);
        send_beat(make_item(REQ_SAMPLE, 16'h4000, 0, 0));
        send_beat(make_item(REQ_INTEGRATE, 16'h0, 10, 0));
        send_beat(make_item(REQ_DEMAND, 16'h0, 10, 0));
        drain();

        for (int ph = 0; ph < 7; ph++) begin
            case (ph % 4)
                0: lim = 32'hffff_ffff;
                1: lim = 0;
                2: lim = $urandom_range(0, 4000);
                default: lim = $urandom;
            endcase
            write_reg(CFG_RUN, (ph == 3) ? 0 : 1);
            write_reg(CFG_PT_RATIO, (ph == 0) ? 1 : (ph == 1) ? 1000 :
                                    (ph == 2) ? 1023 : $urandom_range(1, 1000));
            write_reg(CFG_INTERVAL, (ph == 0) ? 1 : (ph == 1) ? 60 : $urandom_range(0, 63));
            write_reg(CFG_PEAK_START, $urandom_range(0, 31));
            write_reg(CFG_PEAK_END, $urandom_range(0, 31));
            write_reg(CFG_LIMIT, lim);
            calm = (ph == 4);
            for (int i = 0; i < ((ph == 3) ? 40 : 225); i++)
                send_beat(rand_item());
            drain();
        end

        if (errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// ===== energy_demand_integrator.f =====
+incdir+rtl/core
rtl/core/edi_pkg.sv
rtl/core/edi_ram.sv
rtl/core/edi_div.sv
rtl/core/energy_demand_integrator.sv
tb/edi_checker.sv
tb/tb_top.sv
